FILE: rtl/fadr_pkg.sv
// Shared constants, types and register codes of the fader average deadband reporter.
package fadr_pkg;

  // Block geometry.
  localparam int unsigned Window       = 8;
  localparam int unsigned Channels     = 4;
  localparam int unsigned SampleBits   = 12;
  localparam int unsigned WinLog2      = $clog2(Window);
  localparam int unsigned ChanBits     = 2;
  localparam int unsigned SumBits      = SampleBits + WinLog2;

  // Controller value scaling: average / 32, saturated to 7 bits.
  localparam int unsigned ValueDivLog2 = 5;
  localparam int unsigned ValueBits    = 7;
  localparam int unsigned ValueMax     = 127;

  // Configuration port.
  localparam int unsigned MaskBits     = 4;
  localparam int unsigned MidiChBits   = 4;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 7;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [SumBits-1:0]    sum_t;
  typedef logic [ValueBits-1:0]  value_t;
  typedef logic [ChanBits-1:0]   chan_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgReportMask     = 2'd0,
    CfgChangeThresh   = 2'd1,
    CfgMidiChannel    = 2'd2,
    CfgControllerBase = 2'd3
  } cfg_reg_e;

  // Per-channel state seen by the evaluation logic.
  typedef struct packed {
    sample_t oldest;
    sum_t    sum;
    value_t  last;
  } chan_rd_t;

  // Per-channel state update produced by the evaluation logic.
  typedef struct packed {
    logic    upd;
    chan_t   ch;
    sample_t smp;
    sum_t    sum;
    logic    upd_last;
    value_t  val;
  } chan_wr_t;

endpackage

FILE: rtl/fadr_chan_store.sv
// Per-channel sample windows, running sums and last reported values.
module fadr_chan_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fadr_pkg::chan_t     rd_ch_i,
  output fadr_pkg::chan_rd_t  rd_o,
  input  fadr_pkg::chan_wr_t  wr_i
);

  // Each window is a shift line: the newest sample enters at tap 0 and the
  // oldest one sits at the last tap.
  logic [fadr_pkg::Window-1:0][fadr_pkg::SampleBits-1:0] ring_q [fadr_pkg::Channels];
  fadr_pkg::sum_t   sum_q  [fadr_pkg::Channels];
  fadr_pkg::value_t last_q [fadr_pkg::Channels];

  // Read side for the channel in the input register.
  assign rd_o.oldest = ring_q[rd_ch_i][fadr_pkg::Window-1];
  assign rd_o.sum    = sum_q[rd_ch_i];
  assign rd_o.last   = last_q[rd_ch_i];

  // Update the addressed channel when a beat leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < fadr_pkg::Channels; c++) begin
        ring_q[c] <= '0;
        sum_q[c]  <= '0;
        last_q[c] <= '0;
      end
    end else if (wr_i.upd) begin
      ring_q[wr_i.ch] <= {ring_q[wr_i.ch][fadr_pkg::Window-2:0], wr_i.smp};
      sum_q[wr_i.ch]  <= wr_i.sum;
      if (wr_i.upd_last) begin
        last_q[wr_i.ch] <= wr_i.val;
      end
    end
  end

endmodule

FILE: rtl/fadr_eval.sv
// Average, scaling and deadband decision for one sample.
module fadr_eval (
  input  logic                              vld_i,
  input  fadr_pkg::chan_t                   ch_i,
  input  fadr_pkg::sample_t                 smp_i,
  input  fadr_pkg::chan_rd_t                rd_i,
  input  logic [fadr_pkg::MaskBits-1:0]     mask_i,
  input  fadr_pkg::value_t                  thresh_i,
  output fadr_pkg::chan_wr_t                wr_o,
  output logic                              fire_o,
  output fadr_pkg::value_t                  val_o
);

  fadr_pkg::sum_t   sum_new;
  fadr_pkg::sum_t   avg;
  fadr_pkg::sum_t   val_wide;
  fadr_pkg::value_t val;
  fadr_pkg::value_t diff;

  // Swap the oldest sample for the new one; the sum never leaves its range.
  assign sum_new = rd_i.sum - fadr_pkg::SumBits'(rd_i.oldest) + fadr_pkg::SumBits'(smp_i);

  // Window and value divisors are powers of two.
  assign avg      = sum_new >> fadr_pkg::WinLog2;
  assign val_wide = avg >> fadr_pkg::ValueDivLog2;
  assign val      = (val_wide > fadr_pkg::SumBits'(fadr_pkg::ValueMax))
                    ? fadr_pkg::ValueBits'(fadr_pkg::ValueMax)
                    : val_wide[fadr_pkg::ValueBits-1:0];

  // Absolute change against the last reported value.
  assign diff = (val >= rd_i.last) ? (val - rd_i.last) : (rd_i.last - val);

  assign fire_o = vld_i && mask_i[ch_i] && (diff >= thresh_i);
  assign val_o  = val;

  assign wr_o.upd      = vld_i;
  assign wr_o.ch       = ch_i;
  assign wr_o.smp      = smp_i;
  assign wr_o.sum      = sum_new;
  assign wr_o.upd_last = fire_o;
  assign wr_o.val      = val;

endmodule

FILE: rtl/fader_average_deadband_reporter.sv
// Top level of the four-channel fader averager with deadband change reports.
//
// The block takes one sample beat per clock cycle and keeps that pace as long
// as result beats are taken. A beat is held in an input register; as it
// leaves that register, its channel's 8-sample window, running sum and last reported
// value (all flip-flops, cleared by reset, no clearing pass) are read, updated
// and written back, and a report, if one is due, is loaded into the result
// register, where it waits until it is taken.
// Only a result that is not taken holds the input register and with it
// in_ready_o. Configuration writes are always taken and act on the next sample
// evaluated.
module fader_average_deadband_reporter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [fadr_pkg::ChanBits-1:0]       fader_index_i,
  input  logic [fadr_pkg::SampleBits-1:0]     sample_i,
  // Report channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fadr_pkg::ChanBits-1:0]       report_fader_o,
  output logic [fadr_pkg::MidiChBits-1:0]     report_midi_channel_o,
  output logic [fadr_pkg::ValueBits-1:0]      controller_number_o,
  output logic [fadr_pkg::ValueBits-1:0]      controller_value_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fadr_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [fadr_pkg::CfgDataBits-1:0]    cfg_data_i
);

  logic [fadr_pkg::MaskBits-1:0]   mask_q;
  fadr_pkg::value_t                thresh_q;
  logic [fadr_pkg::MidiChBits-1:0] midi_q;
  fadr_pkg::value_t                base_q;

  logic               in_vld_q;
  fadr_pkg::chan_t    in_ch_q;
  fadr_pkg::sample_t  in_smp_q;

  logic                              out_vld_q;
  fadr_pkg::chan_t                   out_ch_q;
  logic [fadr_pkg::MidiChBits-1:0]   out_midi_q;
  fadr_pkg::value_t                  out_num_q;
  fadr_pkg::value_t                  out_val_q;

  logic               adv;
  logic               fire;
  fadr_pkg::value_t   val;
  fadr_pkg::chan_rd_t rd;
  fadr_pkg::chan_wr_t wr;
  fadr_pkg::chan_wr_t wr_gated;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= fadr_pkg::MaskBits'(1);
      thresh_q <= fadr_pkg::ValueBits'(2);
      midi_q   <= '0;
      base_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (fadr_pkg::cfg_reg_e'(cfg_index_i))
        fadr_pkg::CfgReportMask:     mask_q   <= cfg_data_i[fadr_pkg::MaskBits-1:0];
        fadr_pkg::CfgChangeThresh:   thresh_q <= cfg_data_i[fadr_pkg::ValueBits-1:0];
        fadr_pkg::CfgMidiChannel:    midi_q   <= cfg_data_i[fadr_pkg::MidiChBits-1:0];
        fadr_pkg::CfgControllerBase: base_q   <= cfg_data_i[fadr_pkg::ValueBits-1:0];
        default: ;
      endcase
    end
  end

  // The input register drains whenever the result register can take a beat.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_ch_q  <= fader_index_i;
      in_smp_q <= sample_i;
    end
  end

  // Channel state and evaluation.
  fadr_chan_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_ch_i (in_ch_q),
    .rd_o    (rd),
    .wr_i    (wr_gated)
  );

  fadr_eval u_eval (
    .vld_i    (adv),
    .ch_i     (in_ch_q),
    .smp_i    (in_smp_q),
    .rd_i     (rd),
    .mask_i   (mask_q),
    .thresh_i (thresh_q),
    .wr_o     (wr),
    .fire_o   (fire),
    .val_o    (val)
  );

  assign wr_gated = wr;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fire;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fire) begin
      out_ch_q   <= in_ch_q;
      out_midi_q <= midi_q;
      out_num_q  <= base_q + fadr_pkg::ValueBits'(in_ch_q);
      out_val_q  <= val;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign report_fader_o        = out_ch_q;
  assign report_midi_channel_o = out_midi_q;
  assign controller_number_o   = out_num_q;
  assign controller_value_o    = out_val_q;

  // An accepted sample beat always lands in the input register.
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_vld_q)
    else $error("accepted sample beat not held in input register");

  // A stalled report holds the input register and the channel state.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |-> !adv && !wr_gated.upd)
    else $error("state updated while report stalled");

  // A new report only comes from an evaluated sample that fired.
  a_report_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv) && $past(fire))
    else $error("report appeared without a firing sample");

endmodule
